FILE: rtl/cfpq_pkg.sv
`timescale 1ns / 1ps
package cfpq_pkg;

  // Fixed identifier width and maximum data length of the frame format.
  localparam int unsigned IdWidth   = 11;
  localparam int unsigned MaxDlc    = 8;

  // Input commands.
  typedef enum logic [1:0] {
    CMD_FRAME   = 2'd0,
    CMD_FILL    = 2'd1,
    CMD_PROGRAM = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_FRAME   = 2'd0,
    KIND_SUMMARY = 2'd1,
    KIND_BAD_ID  = 2'd2
  } kind_e;

  // Slot filter modes.
  typedef enum logic [1:0] {
    MODE_NEVER  = 2'd0,
    MODE_ALWAYS = 2'd1,
    MODE_TIMED  = 2'd2,
    MODE_COUNT  = 2'd3
  } slot_mode_e;

  // One entry of the slot table.
  typedef struct packed {
    slot_mode_e  mode;
    logic [15:0] setting;
    logic [31:0] last_sent;
    logic [15:0] skip;
  } slot_entry_t;

  // One queued frame.
  typedef struct packed {
    logic [IdWidth-1:0] id;
    logic               rtr;
    logic [3:0]         dlc;
    logic [63:0]        data;
  } frame_t;

  // Mask that keeps the low dlc bytes of a payload word.
  function automatic logic [63:0] byte_mask(input logic [3:0] dlc);
    logic [63:0] mask;
    mask = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < dlc) begin
        mask[b*8 +: 8] = 8'hFF;
      end
    end
    return mask;
  endfunction

endpackage

FILE: rtl/can_frame_decimating_packet_queue_unit.sv
`timescale 1ns / 1ps
// Frame and program-slot words each go through one slot table read, then the write back.
// A frame with a bad identifier waits in ST_BAD for any output stall; a program word with one is dropped.
// A fill is accepted, then each packed frame takes a head read of the frame store and a room check,
// then the summary word takes another head read and room check; each room check waits out any output stall.
// After reset a sweep clears all SLOT_COUNT entries of the slot table; in_stall_o stays high
// until the cycle after the sweep ends.
module can_frame_decimating_packet_queue_unit #(
  parameter int unsigned SLOT_COUNT       = 2048,
  parameter int unsigned QUEUE_DEPTH      = 128,
  parameter int unsigned MAX_PACKET_BYTES = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [15:0] identifier_i,
  input  logic        remote_request_i,
  input  logic [3:0]  data_length_i,
  input  logic [63:0] payload_data_i,
  input  logic [31:0] now_ms_i,
  input  logic [7:0]  buffer_length_i,
  input  logic [1:0]  new_mode_i,
  input  logic [15:0] new_setting_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [15:0] header_word_o,
  output logic [63:0] frame_payload_o,
  output logic [3:0]  payload_len_o,
  output logic [5:0]  frames_packed_o,
  output logic [7:0]  frames_left_o,
  output logic        last_o
);
  import cfpq_pkg::*;

  localparam int unsigned SlotW = $clog2(SLOT_COUNT);
  localparam int unsigned CntW  = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [5:0] {
    ST_CLEAR    = 6'b000001,
    ST_IDLE     = 6'b000010,
    ST_EVAL     = 6'b000100,
    ST_BAD      = 6'b001000,
    ST_FILL_RD  = 6'b010000,
    ST_FILL_CHK = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Latched input word.
  cmd_e               cmd_q;
  logic [SlotW-1:0]   slot_q;
  logic [IdWidth-1:0] id_q;
  logic               rtr_q;
  logic [3:0]         dlc_q;
  logic [63:0]        data_q;
  logic [31:0]        now_q;
  logic [7:0]         blen_q;
  slot_mode_e         mode_q;
  logic [15:0]        setting_q;

  // Fill progress.
  logic [7:0] idx_q, idx_d;
  logic [5:0] packed_q, packed_d;

  // Output register.
  logic        out_valid_q, out_valid_d;
  kind_e       kind_q, kind_d;
  logic [15:0] header_q, header_d;
  logic [63:0] payload_q, payload_d;
  logic [3:0]  plen_q, plen_d;
  logic [5:0]  opacked_q, opacked_d;
  logic [7:0]  left_q, left_d;
  logic        last_q, last_d;

  logic in_accept, out_free, id_ok;
  logic [3:0] dlc_sat;
  logic [7:0] blen_sat;

  slot_entry_t slot_rdata, slot_wdata;
  logic        slot_we, slot_pass, clear_busy;

  frame_t          push_frame, head_frame;
  logic            push, pop;
  logic [CntW-1:0] q_count;
  logic [8:0]      fill_end;
  logic            fits;

  assign in_accept = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign id_ok     = {1'b0, identifier_i} < 17'(SLOT_COUNT);
  assign dlc_sat   = (data_length_i > 4'(MaxDlc)) ? 4'(MaxDlc) : data_length_i;
  assign blen_sat  = (buffer_length_i > 8'(MAX_PACKET_BYTES)) ?
                     8'(MAX_PACKET_BYTES) : buffer_length_i;

  // Capture the accepted word.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q     <= cmd_e'(command_i);
      slot_q    <= identifier_i[SlotW-1:0];
      id_q      <= identifier_i[IdWidth-1:0];
      rtr_q     <= remote_request_i;
      dlc_q     <= dlc_sat;
      data_q    <= payload_data_i & byte_mask(dlc_sat);
      now_q     <= now_ms_i;
      blen_q    <= blen_sat;
      mode_q    <= slot_mode_e'(new_mode_i);
      setting_q <= new_setting_i;
    end
  end

  // Slot table, read at acceptance and written back in the following cycle.
  cfpq_slot_table #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_slot_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_addr_i   (identifier_i[SlotW-1:0]),
    .wr_en_i     (slot_we),
    .wr_addr_i   (slot_q),
    .wr_data_i   (slot_wdata),
    .rd_data_o   (slot_rdata),
    .clear_busy_o(clear_busy)
  );

  cfpq_slot_filter u_slot_filter (
    .entry_i      (slot_rdata),
    .program_i    (cmd_q == CMD_PROGRAM),
    .now_ms_i     (now_q),
    .new_mode_i   (mode_q),
    .new_setting_i(setting_q),
    .entry_o      (slot_wdata),
    .pass_o       (slot_pass)
  );

  assign slot_we = (state_q == ST_EVAL);
  assign push    = (state_q == ST_EVAL) && (cmd_q == CMD_FRAME) && slot_pass;

  always_comb begin
    push_frame.id   = id_q;
    push_frame.rtr  = rtr_q;
    push_frame.dlc  = dlc_q;
    push_frame.data = data_q;
  end

  cfpq_frame_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_frame_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_frame_i(push_frame),
    .pop_i       (pop),
    .head_frame_o(head_frame),
    .count_o     (q_count)
  );

  // The head frame is taken only while its end stays below the buffer length.
  assign fill_end = {1'b0, idx_q} + 9'd2 + 9'(head_frame.dlc);
  assign fits     = (q_count != '0) && (fill_end < {1'b0, blen_q});
  assign pop      = (state_q == ST_FILL_CHK) && fits && out_free;

  // Sequencer and output register loading.
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    packed_d    = packed_q;
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    header_d    = header_q;
    payload_d   = payload_q;
    plen_d      = plen_q;
    opacked_d   = opacked_q;
    left_d      = left_q;
    last_d      = last_q;
    case (state_q)
      ST_CLEAR: begin
        if (!clear_busy) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          idx_d    = 8'd2;
          packed_d = '0;
          case (cmd_e'(command_i))
            CMD_FRAME:   state_d = id_ok ? ST_EVAL : ST_BAD;
            CMD_FILL:    state_d = ST_FILL_RD;
            CMD_PROGRAM: state_d = id_ok ? ST_EVAL : ST_IDLE;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_EVAL: begin
        state_d = ST_IDLE;
      end
      ST_BAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          kind_d      = KIND_BAD_ID;
          header_d    = '0;
          payload_d   = '0;
          plen_d      = '0;
          opacked_d   = '0;
          left_d      = '0;
          last_d      = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_FILL_RD: begin
        state_d = ST_FILL_CHK;
      end
      ST_FILL_CHK: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (fits) begin
            kind_d    = KIND_FRAME;
            header_d  = {head_frame.id[2:0], head_frame.rtr, head_frame.dlc,
                         head_frame.id[10:3]};
            payload_d = head_frame.data;
            plen_d    = head_frame.dlc;
            opacked_d = '0;
            left_d    = '0;
            last_d    = 1'b0;
            idx_d     = fill_end[7:0];
            packed_d  = packed_q + 1'b1;
            state_d   = ST_FILL_RD;
          end else begin
            kind_d    = KIND_SUMMARY;
            header_d  = '0;
            payload_d = '0;
            plen_d    = '0;
            opacked_d = packed_q;
            left_d    = 8'(q_count);
            last_d    = 1'b1;
            state_d   = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      packed_q    <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      packed_q    <= packed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    header_q  <= header_d;
    payload_q <= payload_d;
    plen_q    <= plen_d;
    opacked_q <= opacked_d;
    left_q    <= left_d;
    last_q    <= last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign header_word_o   = header_q;
  assign frame_payload_o = payload_q;
  assign payload_len_o   = plen_q;
  assign frames_packed_o = opacked_q;
  assign frames_left_o   = left_q;
  assign last_o          = last_q;

endmodule

FILE: rtl/cfpq_slot_table.sv
`timescale 1ns / 1ps
module cfpq_slot_table #(
  parameter int unsigned SLOT_COUNT = 2048,
  parameter int unsigned SlotW      = $clog2(SLOT_COUNT)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [SlotW-1:0]     rd_addr_i,
  input  logic                 wr_en_i,
  input  logic [SlotW-1:0]     wr_addr_i,
  input  cfpq_pkg::slot_entry_t wr_data_i,
  output cfpq_pkg::slot_entry_t rd_data_o,
  output logic                 clear_busy_o
);
  import cfpq_pkg::*;

  slot_entry_t mem [SLOT_COUNT];
  slot_entry_t rd_data_q;
  logic [SlotW-1:0] clr_addr_q, clr_addr_d;
  logic clr_busy_q, clr_busy_d;
  logic             mem_we;
  logic [SlotW-1:0] mem_waddr;
  slot_entry_t      mem_wdata;

  // The clearing sweep owns the write port until every entry is zero.
  always_comb begin
    clr_addr_d = clr_addr_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == SlotW'(SLOT_COUNT - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      clr_addr_q <= clr_addr_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  assign mem_we    = clr_busy_q || wr_en_i;
  assign mem_waddr = clr_busy_q ? clr_addr_q : wr_addr_i;
  assign mem_wdata = clr_busy_q ? slot_entry_t'('0) : wr_data_i;

  // Single write port, registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o    = rd_data_q;
  assign clear_busy_o = clr_busy_q;

endmodule

FILE: rtl/cfpq_slot_filter.sv
`timescale 1ns / 1ps
module cfpq_slot_filter (
  input  cfpq_pkg::slot_entry_t entry_i,
  input  logic                  program_i,
  input  logic [31:0]           now_ms_i,
  input  cfpq_pkg::slot_mode_e  new_mode_i,
  input  logic [15:0]           new_setting_i,
  output cfpq_pkg::slot_entry_t entry_o,
  output logic                  pass_o
);
  import cfpq_pkg::*;

  logic [31:0] elapsed;
  logic [15:0] skip_inc;

  assign elapsed  = now_ms_i - entry_i.last_sent;
  assign skip_inc = entry_i.skip + 16'd1;

  // Modify step of the slot read-modify-write.
  always_comb begin
    entry_o = entry_i;
    pass_o  = 1'b0;
    if (program_i) begin
      entry_o.mode    = new_mode_i;
      entry_o.setting = new_setting_i;
      entry_o.skip    = '0;
    end else begin
      case (entry_i.mode)
        MODE_ALWAYS: begin
          pass_o = 1'b1;
        end
        MODE_TIMED: begin
          if (elapsed > {16'd0, entry_i.setting}) begin
            entry_o.last_sent = now_ms_i;
            pass_o            = 1'b1;
          end
        end
        MODE_COUNT: begin
          entry_o.skip = skip_inc;
          if (skip_inc >= entry_i.setting) begin
            entry_o.skip = '0;
            pass_o       = 1'b1;
          end
        end
        default: begin
          pass_o = 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: rtl/cfpq_frame_queue.sv
`timescale 1ns / 1ps
module cfpq_frame_queue #(
  parameter int unsigned QUEUE_DEPTH = 128,
  parameter int unsigned PtrW        = $clog2(QUEUE_DEPTH),
  parameter int unsigned CntW        = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  cfpq_pkg::frame_t push_frame_i,
  input  logic             pop_i,
  output cfpq_pkg::frame_t head_frame_o,
  output logic [CntW-1:0]  count_o
);
  import cfpq_pkg::*;

  frame_t mem [QUEUE_DEPTH];
  frame_t head_q;
  logic [PtrW-1:0] head_ptr_q, head_ptr_d;
  logic [PtrW-1:0] tail_ptr_q, tail_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;

  // A push into a full queue is dropped.
  assign do_push = push_i && (count_q != CntW'(QUEUE_DEPTH));

  always_comb begin
    head_ptr_d = head_ptr_q;
    tail_ptr_d = tail_ptr_q;
    count_d    = count_q;
    if (do_push) begin
      tail_ptr_d = (tail_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : tail_ptr_q + 1'b1;
      count_d    = count_d + 1'b1;
    end
    if (pop_i) begin
      head_ptr_d = (head_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : head_ptr_q + 1'b1;
      count_d    = count_d - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_ptr_q <= '0;
      tail_ptr_q <= '0;
      count_q    <= '0;
    end else begin
      head_ptr_q <= head_ptr_d;
      tail_ptr_q <= tail_ptr_d;
      count_q    <= count_d;
    end
  end

  // Frame store: write at the tail, registered read at the head.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[tail_ptr_q] <= push_frame_i;
    end
    head_q <= mem[head_ptr_q];
  end

  assign head_frame_o = head_q;
  assign count_o      = count_q;

endmodule
